### rtl/mld_pkg.sv
// ----------------------------------------------------------------------------
// mld_pkg
// Shared constants, kind codes and the result record of the magic/length
// deframer.
// ----------------------------------------------------------------------------
package mld_pkg;

	localparam int LENGTH_BITS = 32;
	localparam logic [31:0] LEN_MASK = 32'((64'd1 << LENGTH_BITS) - 64'd1);

	localparam logic [31:0] SYNC_RESET = 32'h4243_4C52;

	localparam logic [2:0] KIND_HUNT = 3'd0;
	localparam logic [2:0] KIND_SYNC = 3'd1;
	localparam logic [2:0] KIND_HLEN = 3'd2;
	localparam logic [2:0] KIND_PLEN = 3'd3;
	localparam logic [2:0] KIND_HDR  = 3'd4;
	localparam logic [2:0] KIND_PAY  = 3'd5;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic [2:0]  byte_kind;
		logic [31:0] region_offset;
		logic        region_last;
		logic        frame_end;
		logic [31:0] header_length;
		logic [31:0] payload_length;
	} res_t;

endpackage

### rtl/mld_step.sv
// ----------------------------------------------------------------------------
// mld_step
// Frame state machine: sync hunt window, length capture and region counting.
// Produces the result for one byte and updates state when enabled.
// ----------------------------------------------------------------------------
module mld_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       sync_word,
	output mld_pkg::res_t     res
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LENS,
		PH_HDR,
		PH_PAY
	} phase_t;

	phase_t      ph_q, ph_d;
	logic [23:0] win_q, win_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [31:0] hl_q, hl_d;
	logic [31:0] pl_q, pl_d;
	logic [31:0] rc_q, rc_d;
	logic [2:0]  kind;
	logic [31:0] off;
	logic        rl;
	logic        fe;
	logic [31:0] ins;

	always_comb begin
		ph_d  = ph_q;
		win_d = win_q;
		cnt_d = cnt_q;
		hl_d  = hl_q;
		pl_d  = pl_q;
		rc_d  = rc_q;
		kind  = mld_pkg::KIND_HUNT;
		off   = '0;
		rl    = 1'b0;
		fe    = 1'b0;
		ins   = 32'(data_byte) << {cnt_q[1:0], 3'b000};
		unique case (ph_q)
			PH_HUNT: begin
				if (cnt_q >= 3'd3 && {data_byte, win_q} == sync_word) begin
					kind  = mld_pkg::KIND_SYNC;
					ph_d  = PH_LENS;
					win_d = '0;
					cnt_d = '0;
					hl_d  = '0;
					pl_d  = '0;
					rc_d  = '0;
				end else begin
					win_d = {data_byte, win_q[23:8]};
					if (cnt_q < 3'd3)
						cnt_d = cnt_q + 3'd1;
				end
			end
			PH_LENS: begin
				if (!cnt_q[2]) begin
					kind = mld_pkg::KIND_HLEN;
					hl_d = (cnt_q[1:0] == 2'd3) ? ((hl_q | ins) & mld_pkg::LEN_MASK)
						: (hl_q | ins);
				end else begin
					kind = mld_pkg::KIND_PLEN;
					pl_d = (cnt_q[1:0] == 2'd3) ? ((pl_q | ins) & mld_pkg::LEN_MASK)
						: (pl_q | ins);
				end
				if (cnt_q == 3'd7) begin
					rc_d  = '0;
					cnt_d = '0;
					if (hl_d != '0) begin
						ph_d = PH_HDR;
					end else if (pl_d != '0) begin
						ph_d = PH_PAY;
					end else begin
						fe    = 1'b1;
						ph_d  = PH_HUNT;
						win_d = '0;
					end
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			PH_HDR: begin
				kind = mld_pkg::KIND_HDR;
				off  = rc_q;
				if ({1'b0, rc_q} + 33'd1 >= {1'b0, hl_q}) begin
					rl   = 1'b1;
					rc_d = '0;
					if (pl_q != '0) begin
						ph_d = PH_PAY;
					end else begin
						fe    = 1'b1;
						ph_d  = PH_HUNT;
						win_d = '0;
						cnt_d = '0;
					end
				end else begin
					rc_d = rc_q + 32'd1;
				end
			end
			PH_PAY: begin
				kind = mld_pkg::KIND_PAY;
				off  = rc_q;
				if ({1'b0, rc_q} + 33'd1 >= {1'b0, pl_q}) begin
					rl    = 1'b1;
					fe    = 1'b1;
					ph_d  = PH_HUNT;
					win_d = '0;
					cnt_d = '0;
					rc_d  = '0;
				end else begin
					rc_d = rc_q + 32'd1;
				end
			end
		endcase
	end

	assign res.byte_out       = data_byte;
	assign res.byte_kind      = kind;
	assign res.region_offset  = off;
	assign res.region_last    = rl;
	assign res.frame_end      = fe;
	assign res.header_length  = hl_d;
	assign res.payload_length = pl_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HUNT;
			win_q <= '0;
			cnt_q <= '0;
			hl_q  <= '0;
			pl_q  <= '0;
			rc_q  <= '0;
		end else if (en) begin
			ph_q  <= ph_d;
			win_q <= win_d;
			cnt_q <= cnt_d;
			hl_q  <= hl_d;
			pl_q  <= pl_d;
			rc_q  <= rc_d;
		end
	end

endmodule

### rtl/magic_length_deframer.sv
// ----------------------------------------------------------------------------
// magic_length_deframer
// Byte-stream deframer: hunts a 4-byte sync word, reads little-endian header
// and payload lengths, then tags every following byte by region.
//
//   channel   signals                          direction
//   in        in_valid in_ready data_byte      sink
//   out       out_valid out_ready result bus   source
//   cfg       cfg_valid cfg_ready cfg_data     sink, sync word
//
// one byte per clock sustained while out_ready stays high; input to result path:
// input register then state machine step into the result register
// out_ready low holds the result; the input register fills, then in_ready drops
// reset restores the default sync word and starts hunting, no clearing pass
// ----------------------------------------------------------------------------
module magic_length_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  byte_out,
	output logic [2:0]  byte_kind,
	output logic [31:0] region_offset,
	output logic        region_last,
	output logic        frame_end,
	output logic [31:0] header_length,
	output logic [31:0] payload_length,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic          v_s1;
	logic [7:0]    byte_s1;
	logic          v_s2;
	mld_pkg::res_t res_s2;
	mld_pkg::res_t res;
	logic [31:0]   sync_q;
	logic          adv;

	assign adv       = v_s1 && (!v_s2 || out_ready);
	assign in_ready  = !v_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			sync_q <= mld_pkg::SYNC_RESET;
		else if (cfg_valid)
			sync_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			byte_s1 <= data_byte;
	end

	mld_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.data_byte (byte_s1),
		.sync_word (sync_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= 1'b1;
		else if (out_ready)
			v_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid      = v_s2;
	assign byte_out       = res_s2.byte_out;
	assign byte_kind      = res_s2.byte_kind;
	assign region_offset  = res_s2.region_offset;
	assign region_last    = res_s2.region_last;
	assign frame_end      = res_s2.frame_end;
	assign header_length  = res_s2.header_length;
	assign payload_length = res_s2.payload_length;

	// no offset or region end outside header and payload bytes
	a_no_region_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (byte_kind == mld_pkg::KIND_HUNT || byte_kind == mld_pkg::KIND_SYNC
		|| byte_kind == mld_pkg::KIND_HLEN || byte_kind == mld_pkg::KIND_PLEN)
		|-> region_offset == '0 && !region_last)
		else $error("region fields set outside a region");

	// frame end only on a region end or on the last length byte
	a_frame_end_place: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> region_last || byte_kind == mld_pkg::KIND_PLEN)
		else $error("frame end on an unexpected byte");

	// input stall only while the input register holds a byte
	a_stall_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && v_s2 && !out_ready)
		else $error("input stalled without backpressure");

endmodule

### dv/mld_frame_checker.sv
// ----------------------------------------------------------------------------
// mld_frame_checker
// Watches the byte, result and sync word channels of the deframer. It keeps
// its own copy of the hunt/length/region state machine, tags every accepted
// byte with the fields it expects, and compares each result transfer field by
// field against the oldest tagged byte still due.
// ----------------------------------------------------------------------------
module mld_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  byte_out,
	input  logic [2:0]  byte_kind,
	input  logic [31:0] region_offset,
	input  logic        region_last,
	input  logic        frame_end,
	input  logic [31:0] header_length,
	input  logic [31:0] payload_length,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          results_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {HUNTING, LENGTHS, HEADER, PAYLOAD} phase_t;

	logic [31:0] sync_word_q;
	phase_t      phase_q;
	logic [23:0] window_q;
	logic [2:0]  count_q;
	logic [31:0] hlen_q;
	logic [31:0] plen_q;
	logic [31:0] offset_cnt_q;

	mld_pkg::res_t tagged_bytes_due[$];
	int            errors;
	int            results_seen;

	initial begin
		mismatches = 0;
		results_due = 0;
	end

	function automatic void restart_hunt();
		phase_q = HUNTING;
		window_q = '0;
		count_q = '0;
		offset_cnt_q = '0;
	endfunction

	function automatic mld_pkg::res_t deframe_step(input logic [7:0] b);
		mld_pkg::res_t r;
		logic [31:0] cand;
		logic [2:0] n;
		r = '0;
		r.byte_out = b;
		r.byte_kind = mld_pkg::KIND_HUNT;
		case (phase_q)
			HUNTING: begin
				cand = {b, window_q};
				if (count_q >= 3'd3 && cand == sync_word_q) begin
					r.byte_kind = mld_pkg::KIND_SYNC;
					phase_q = LENGTHS;
					window_q = '0;
					count_q = '0;
					hlen_q = '0;
					plen_q = '0;
					offset_cnt_q = '0;
				end else begin
					window_q = {b, window_q[23:8]};
					if (count_q < 3'd3)
						count_q = count_q + 3'd1;
				end
			end
			LENGTHS: begin
				n = count_q;
				if (n < 3'd4) begin
					r.byte_kind = mld_pkg::KIND_HLEN;
					hlen_q = hlen_q | (32'(b) << {n[1:0], 3'b000});
					if (n == 3'd3)
						hlen_q = hlen_q & mld_pkg::LEN_MASK;
				end else begin
					r.byte_kind = mld_pkg::KIND_PLEN;
					plen_q = plen_q | (32'(b) << {n[1:0], 3'b000});
					if (n == 3'd7)
						plen_q = plen_q & mld_pkg::LEN_MASK;
				end
				if (n == 3'd7) begin
					offset_cnt_q = '0;
					count_q = '0;
					if (hlen_q != 0) begin
						phase_q = HEADER;
					end else if (plen_q != 0) begin
						phase_q = PAYLOAD;
					end else begin
						r.frame_end = 1'b1;
						restart_hunt();
					end
				end else begin
					count_q = n + 3'd1;
				end
			end
			HEADER: begin
				r.byte_kind = mld_pkg::KIND_HDR;
				r.region_offset = offset_cnt_q;
				if ({1'b0, offset_cnt_q} + 33'd1 >= {1'b0, hlen_q}) begin
					r.region_last = 1'b1;
					offset_cnt_q = '0;
					if (plen_q != 0) begin
						phase_q = PAYLOAD;
					end else begin
						r.frame_end = 1'b1;
						restart_hunt();
					end
				end else begin
					offset_cnt_q = offset_cnt_q + 32'd1;
				end
			end
			default: begin
				r.byte_kind = mld_pkg::KIND_PAY;
				r.region_offset = offset_cnt_q;
				if ({1'b0, offset_cnt_q} + 33'd1 >= {1'b0, plen_q}) begin
					r.region_last = 1'b1;
					r.frame_end = 1'b1;
					restart_hunt();
				end else begin
					offset_cnt_q = offset_cnt_q + 32'd1;
				end
			end
		endcase
		r.header_length = hlen_q;
		r.payload_length = plen_q;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: result %0d %s expected %0h, actual %0h",
				$time, results_seen, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mld_pkg::res_t want;
		mld_pkg::res_t next_tag;
		if (!arst_n) begin
			sync_word_q = mld_pkg::SYNC_RESET;
			hlen_q = '0;
			plen_q = '0;
			restart_hunt();
			tagged_bytes_due.delete();
			results_due <= 0;
		end else begin
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (tagged_bytes_due.size() == 0) begin
					errors++;
					$display("%0t ns: result transfer with nothing due, expected none, actual byte %0h",
						$time, byte_out);
				end else begin
					want = tagged_bytes_due.pop_front();
					check_field("byte_out", want.byte_out, byte_out);
					check_field("byte_kind", want.byte_kind, byte_kind);
					check_field("region_offset", want.region_offset, region_offset);
					check_field("region_last", want.region_last, region_last);
					check_field("frame_end", want.frame_end, frame_end);
					check_field("header_length", want.header_length, header_length);
					check_field("payload_length", want.payload_length, payload_length);
				end
				results_seen++;
			end
			if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
				sync_word_q = cfg_data;
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				next_tag = deframe_step(data_byte);
				tagged_bytes_due.insert(tagged_bytes_due.size(), next_tag);
			end
			results_due <= tagged_bytes_due.size();
			mismatches <= errors;
		end
	end

endmodule

### dv/magic_length_deframer_test.sv
// ----------------------------------------------------------------------------
// magic_length_deframer_test
// Drives framed byte streams into the deframer under several sync words:
// clean frames with random lengths and content, empty regions, sync words
// buried in payloads, partial and broken sync words and plain noise. Both
// channels stall in random bursts; a frame checker beside the block scores
// every result transfer.
// ----------------------------------------------------------------------------
module magic_length_deframer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES = 64;
	localparam int PHASE_BYTES = 330;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  byte_out;
	logic [2:0]  byte_kind;
	logic [31:0] region_offset;
	logic        region_last;
	logic        frame_end;
	logic [31:0] header_length;
	logic [31:0] payload_length;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'h0;

	int          mismatches;
	int          results_due;

	logic [31:0] cur_sync = mld_pkg::SYNC_RESET;
	bit          tx_gaps = 1'b1;
	bit          rx_gaps = 1'b1;
	bit          hold_request = 1'b0;
	int          bytes_sent = 0;
	int          frames_sent = 0;
	int          empty_region_frames = 0;
	int          sync_settings = 1;

	magic_length_deframer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_out       (byte_out),
		.byte_kind      (byte_kind),
		.region_offset  (region_offset),
		.region_last    (region_last),
		.frame_end      (frame_end),
		.header_length  (header_length),
		.payload_length (payload_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	mld_frame_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_out       (byte_out),
		.byte_kind      (byte_kind),
		.region_offset  (region_offset),
		.region_last    (region_last),
		.frame_end      (frame_end),
		.header_length  (header_length),
		.payload_length (payload_length),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.results_due    (results_due)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// result side: random stall bursts, plus one long hold on request
	initial begin
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic push_byte(input logic [7:0] b);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		bytes_sent++;
	endtask

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++)
			push_byte(w[8*i +: 8]);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sync(input logic [31:0] w);
		cfg_valid <= 1'b1;
		cfg_data <= w;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		cur_sync = w;
		sync_settings++;
	endtask

	task automatic send_frame(input logic [31:0] hlen, input logic [31:0] plen,
			input bit embed_sync);
		int pos;
		pos = (embed_sync && plen >= 4) ? $urandom_range(0, plen - 4) : -1;
		push_word(cur_sync);
		push_word(hlen);
		push_word(plen);
		for (int i = 0; i < hlen; i++)
			push_byte(8'($urandom));
		for (int i = 0; i < plen; i++) begin
			if (pos >= 0 && i >= pos && i < pos + 4)
				push_byte(cur_sync[8*(i-pos) +: 8]);
			else
				push_byte(8'($urandom));
		end
		frames_sent++;
		if (hlen == 0 || plen == 0)
			empty_region_frames++;
	endtask

	function automatic logic [31:0] pick_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 0;
		else if (r < 8)
			return $urandom_range(1, 8);
		else if (r == 8)
			return $urandom_range(9, 24);
		return $urandom_range(25, 60);
	endfunction

	task automatic random_traffic(input int target);
		int pick;
		int k;
		while (bytes_sent < target) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				send_frame(pick_len(), pick_len(), $urandom_range(0, 3) == 0);
			end else if (pick == 7) begin
				repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
			end else if (pick == 8) begin
				// sync word cut short, then garbage
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++)
					push_byte(cur_sync[8*i +: 8]);
				push_byte(8'($urandom));
			end else begin
				// stray first sync byte, the window must still lock one byte later
				push_byte(cur_sync[7:0]);
				send_frame(pick_len(), pick_len(), 1'b0);
			end
		end
	endtask

	initial begin
		logic [31:0] sync_plan[6];
		int leftover;
		sync_plan[0] = 32'h0000_0000;
		sync_plan[1] = 32'hFFFF_FFFF;
		sync_plan[2] = 32'h4141_4141;
		sync_plan[3] = $urandom;
		sync_plan[4] = mld_pkg::SYNC_RESET;
		sync_plan[5] = $urandom;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: partial sync recovered by the window, byte extremes, empty frame
		push_byte(cur_sync[7:0]);
		push_word(cur_sync);
		push_word(32'd1);
		push_word(32'd2);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(cur_sync[7:0]);
		send_frame(32'd0, 32'd0, 1'b0);

		for (int p = 0; p < 6; p++) begin
			drain_results();
			write_sync(sync_plan[p]);
			if (p == 1)
				hold_request = 1'b1;
			if (p == 5) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			random_traffic(bytes_sent + PHASE_BYTES);
		end

		// length fields at their extremes; the frame stays open to the end
		push_word(cur_sync);
		push_word(32'hFFFF_FFFF);
		push_word(32'h8000_0001);
		repeat (40) push_byte(8'($urandom));
		frames_sent++;

		in_valid <= 1'b0;
		@(posedge clk);
		for (int w = 0; w < 20000 && results_due != 0; w++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		leftover = results_due;
		if (leftover != 0)
			$display("%0t ns: results never delivered, expected 0, actual %0d",
				$time, leftover);

		$display("covered %0d bytes in %0d frames (%0d with an empty region) under %0d sync words",
			bytes_sent, frames_sent, empty_region_frames, sync_settings);
		$display("with random stalls on both sides, one long output hold and full drains");
		if (mismatches == 0 && leftover == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
